/* rtl/smx_pkg.sv */
// Shared types and constants for the stack machine executor.
// Used by smx_cell, smx_iter, stack_machine_executor and the testbench; no dependencies.
package smx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0,
        OP_POP  = 4'd1,
        OP_IN   = 4'd2,
        OP_OUT  = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_MUL  = 4'd6,
        OP_DIV  = 4'd7,
        OP_SQRT = 4'd8,
        OP_SIN  = 4'd9,
        OP_COS  = 4'd10,
        OP_DUMP = 4'd11,
        OP_HALT = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADOP   = 3'd1,
        ST_UNDER   = 3'd2,
        ST_OVER    = 3'd3,
        ST_DIVZ    = 3'd4,
        ST_NEGSQ   = 3'd5,
        ST_IGNORED = 3'd6
    } status_t;

    // Stack move applied to every cell of the row in the same cycle.
    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_PUSH,
        ACT_POP,
        ACT_REPLACE,
        ACT_POPREP
    } act_t;

    typedef struct packed {
        act_t              act;
        logic [WORD_W-1:0] top_value;
    } cell_ctl_t;

endpackage

/* rtl/stack_machine_executor.sv */
// Stack machine executor top level: control sequencer, row of stack cells,
// iterative divide/sqrt unit. Depends on smx_pkg, smx_cell, smx_iter.
//
// Usage:
//  - Input channel s_valid/s_ready carries one instruction per beat:
//    s_op (opcode) and s_operand (immediate for push, entered value for in).
//  - Result channel m_valid/m_ready carries one result beat per instruction:
//    m_out_valid/m_out_value (value popped by out), m_halted, m_status.
//  - The stack is a row of STACK_DEPTH cells; the top word sits in cell 0.
//    Push shifts the row down, pop shifts it up, all cells in the same cycle.
//  - Steps: accept, execute, result for push, pop, in, out, add, sub,
//    mul, sin, cos, dump and halt. Divide and square root add an iterate
//    step in smx_iter (one quotient bit a cycle, or one root bit a cycle).
//    One instruction is in flight at a time, so the next one is taken
//    only after the current one leaves its result step.
//  - A finished result waits in the output register; the next instruction
//    is accepted meanwhile and holds in its result cycle until that register
//    frees up, so a stalled receiver stops the block after one beat.
//  - Reset (aresetn low, synchronous) empties the stack, clears the halt
//    flag and drops any pending result. Stack words need no clearing.
//  - After halt or an error every later instruction is answered with
//    status "ignored after halt" and leaves the stack unchanged.
module stack_machine_executor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [3:0]                  s_op,
    input  logic signed [31:0]          s_operand,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_out_valid,
    output logic signed [31:0]          m_out_value,
    output logic                        m_halted,
    output logic [2:0]                  m_status
);
    import smx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_ITER = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0]          op_reg;
    logic [WORD_W-1:0]   operand_reg;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                halted_reg, halted_next;
    logic                neg_reg, neg_next;
    logic                sqrt_op_reg, sqrt_op_next;

    // Pending result of the current instruction
    logic                pend_ov_reg, pend_ov_next;
    logic [WORD_W-1:0]   pend_val_reg, pend_val_next;
    logic [2:0]          pend_st_reg, pend_st_next;

    // Output register
    logic                m_valid_reg;
    logic                m_ov_reg;
    logic [WORD_W-1:0]   m_val_reg;
    logic                m_halt_reg;
    logic [2:0]          m_st_reg;

    logic [WORD_W-1:0]   word [STACK_DEPTH];
    cell_ctl_t           ctl;
    logic                iter_start;
    logic                iter_done;
    logic [WORD_W-1:0]   iter_res;
    logic [WORD_W-1:0]   iter_num, iter_den;
    logic [WORD_W-1:0]   top0, top1;
    logic [WORD_W-1:0]   prod;
    logic                out_free;

    assign top0     = word[0];
    assign top1     = word[1];
    assign prod     = top1 * top0;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        halted_next   = halted_reg;
        neg_next      = neg_reg;
        sqrt_op_next  = sqrt_op_reg;
        pend_ov_next  = pend_ov_reg;
        pend_val_next = pend_val_reg;
        pend_st_next  = pend_st_reg;
        ctl.act       = ACT_HOLD;
        ctl.top_value = '0;
        iter_start    = 1'b0;
        iter_num      = top0;
        iter_den      = top0[31] ? (32'd0 - top0) : top0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                pend_ov_next  = 1'b0;
                pend_val_next = '0;
                pend_st_next  = ST_OK;
                state_next    = S_DONE;
                if (halted_reg) begin
                    pend_st_next = ST_IGNORED;
                end else begin
                    case (op_reg)
                        OP_PUSH, OP_IN: begin
                            if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                                pend_st_next = ST_OVER;
                            end else begin
                                ctl.act       = ACT_PUSH;
                                ctl.top_value = operand_reg;
                                depth_next    = depth_reg + DEPTH_W'(1);
                            end
                        end
                        OP_POP, OP_OUT, OP_SQRT, OP_SIN, OP_COS: begin
                            if (depth_reg == '0) begin
                                pend_st_next = ST_UNDER;
                            end else if (op_reg == OP_POP || op_reg == OP_OUT) begin
                                ctl.act       = ACT_POP;
                                depth_next    = depth_reg - DEPTH_W'(1);
                                pend_ov_next  = (op_reg == OP_OUT);
                                pend_val_next = (op_reg == OP_OUT) ? top0 : '0;
                            end else if (op_reg == OP_SQRT) begin
                                if (top0[31]) begin
                                    pend_st_next = ST_NEGSQ;
                                end else begin
                                    iter_start   = 1'b1;
                                    sqrt_op_next = 1'b1;
                                    neg_next     = 1'b0;
                                    state_next   = S_ITER;
                                end
                            end else begin
                                ctl.act       = ACT_REPLACE;
                                ctl.top_value = (op_reg == OP_COS && top0 == '0)
                                                ? 32'd1 : 32'd0;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (depth_reg < DEPTH_W'(2)) begin
                                pend_st_next = ST_UNDER;
                            end else if (op_reg == OP_DIV) begin
                                if (top0 == '0) begin
                                    pend_st_next = ST_DIVZ;
                                end else begin
                                    iter_start   = 1'b1;
                                    iter_num     = top1[31] ? (32'd0 - top1) : top1;
                                    sqrt_op_next = 1'b0;
                                    neg_next     = top1[31] ^ top0[31];
                                    state_next   = S_ITER;
                                end
                            end else begin
                                ctl.act    = ACT_POPREP;
                                depth_next = depth_reg - DEPTH_W'(1);
                                case (op_reg)
                                    OP_ADD:  ctl.top_value = top1 + top0;
                                    OP_SUB:  ctl.top_value = top1 - top0;
                                    default: ctl.top_value = prod;
                                endcase
                            end
                        end
                        OP_DUMP: ;
                        OP_HALT: halted_next = 1'b1;
                        default: pend_st_next = ST_BADOP;
                    endcase
                    if (pend_st_next != ST_OK) halted_next = 1'b1;
                end
            end
            S_ITER: begin
                if (iter_done) begin
                    // Write back the quotient or root, fix the quotient sign
                    ctl.top_value = neg_reg ? (32'd0 - iter_res) : iter_res;
                    if (sqrt_op_reg) begin
                        ctl.act = ACT_REPLACE;
                    end else begin
                        ctl.act    = ACT_POPREP;
                        depth_next = depth_reg - DEPTH_W'(1);
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            halted_reg <= halted_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        neg_reg      <= neg_next;
        sqrt_op_reg  <= sqrt_op_next;
        pend_ov_reg  <= pend_ov_next;
        pend_val_reg <= pend_val_next;
        pend_st_reg  <= pend_st_next;
        if (s_valid && s_ready) begin
            op_reg      <= s_op;
            operand_reg <= s_operand;
        end
        if (state_reg == S_DONE && out_free) begin
            m_ov_reg   <= pend_ov_reg;
            m_val_reg  <= pend_val_reg;
            m_halt_reg <= halted_reg;
            m_st_reg   <= pend_st_reg;
        end
    end

    // Row of stack cells; cell 0 holds the top of stack
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [WORD_W-1:0] up_d, down_d;
            if (gi == 0) begin : g_top
                assign up_d = '0;
            end else begin : g_mid
                assign up_d = word[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_bot
                assign down_d = '0;
            end else begin : g_nbot
                assign down_d = word[gi+1];
            end
            smx_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .is_top    (gi == 0),
                .up_data   (up_d),
                .down_data (down_d),
                .word      (word[gi])
            );
        end
    endgenerate

    smx_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (iter_start),
        .is_sqrt (sqrt_op_next),
        .num     (iter_num),
        .den     (iter_den),
        .done    (iter_done),
        .result  (iter_res)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_valid = m_ov_reg;
    assign m_out_value = m_val_reg;
    assign m_halted    = m_halt_reg;
    assign m_status    = m_st_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");
    a_iter_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_done |-> (state_reg == S_ITER))
        else $error("iter result outside iterate state");
    a_halted_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && state_reg == S_EXEC) |=> $stable(depth_reg))
        else $error("stack moved after halt");
`endif

endmodule

/* rtl/smx_cell.sv */
// One stack word of the shifting stack row.
// Depends on smx_pkg.
module smx_cell (
    input  logic                      aclk,
    input  smx_pkg::cell_ctl_t        ctl,
    input  logic                      is_top,
    input  logic [smx_pkg::WORD_W-1:0] up_data,
    input  logic [smx_pkg::WORD_W-1:0] down_data,
    output logic [smx_pkg::WORD_W-1:0] word
);
    import smx_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [WORD_W-1:0] from_above;

    assign from_above = is_top ? ctl.top_value : up_data;

    always_comb begin
        word_next = word_reg;
        case (ctl.act)
            ACT_PUSH:    word_next = from_above;
            ACT_POP:     word_next = down_data;
            ACT_REPLACE: if (is_top) word_next = ctl.top_value;
            ACT_POPREP:  word_next = is_top ? ctl.top_value : down_data;
            default:     word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/smx_iter.sv */
// Iterative unsigned divider (one bit a cycle) and floor square root
// (one root bit a cycle). Depends on smx_pkg.
module smx_iter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       is_sqrt,
    input  logic [smx_pkg::WORD_W-1:0] num,
    input  logic [smx_pkg::WORD_W-1:0] den,
    output logic                       done,
    output logic [smx_pkg::WORD_W-1:0] result
);
    import smx_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                sqrt_reg, sqrt_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [WORD_W+1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   quo_reg, quo_next;
    logic [WORD_W-1:0]   src_reg, src_next;
    logic [WORD_W-1:0]   den_reg, den_next;
    logic [WORD_W+1:0]   shifted;
    logic [WORD_W+1:0]   trial;
    logic                last;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        src_next  = src_reg;
        den_next  = den_reg;
        if (sqrt_reg) begin
            shifted = {rem_reg[WORD_W-1:0], src_reg[WORD_W-1 -: 2]};
            trial   = {quo_reg, 2'b01};
            last    = (cnt_reg == CNT_W'(WORD_W / 2 - 1));
        end else begin
            shifted = {rem_reg[WORD_W:0], src_reg[WORD_W-1]};
            trial   = {2'b00, den_reg};
            last    = (cnt_reg == CNT_W'(WORD_W - 1));
        end
        if (start) begin
            busy_next = 1'b1;
            sqrt_next = is_sqrt;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = '0;
            src_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            src_next = sqrt_reg ? {src_reg[WORD_W-3:0], 2'b00}
                                : {src_reg[WORD_W-2:0], 1'b0};
            if (shifted >= trial) begin
                rem_next = shifted - trial;
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sqrt_reg <= sqrt_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        src_reg  <= src_next;
        den_reg  <= den_next;
    end

    assign done   = done_reg;
    assign result = quo_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("iter done without busy");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !done_reg)
        else $error("iter busy and done together");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("iter start lost");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for stack_machine_executor: directed and random
// instruction programs, predicted results in order, random idling on both sides.
// Depends on smx_pkg and the stack_machine_executor RTL.
`timescale 1ns / 1ps

module testbench;
    import smx_pkg::*;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] opd;
    } instr_t;

    typedef struct {
        logic        ov;
        logic [31:0] val;
        logic        hl;
        logic [2:0]  st;
    } answer_t;

    localparam int IDLE_LIMIT = 5000;
    localparam logic [31:0] MIN_W = 32'h8000_0000;
    localparam logic [31:0] MAX_W = 32'h7FFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_op = '0;
    logic signed [31:0] s_operand = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_out_valid;
    logic signed [31:0] m_out_value;
    logic        m_halted;
    logic [2:0]  m_status;

    // Shadow machine state used to predict every answer.
    logic [31:0] shadow_stk [STACK_DEPTH];
    int          shadow_depth = 0;
    logic        shadow_halt = 1'b0;

    instr_t  pending_instrs[$];
    answer_t expected_answers[$];
    int      errors = 0;
    int      beats_out = 0;
    int      idle_cycles = 0;

    stack_machine_executor dut (.*);

    always #1 aclk = ~aclk;

    function automatic logic [31:0] isqrt(logic [31:0] v);
        logic [31:0] root;
        logic [31:0] t;
        root = '0;
        for (int i = 15; i >= 0; i--) begin
            t = root | (32'd1 << i);
            if (64'(t) * 64'(t) <= 64'(v)) root = t;
        end
        return root;
    endfunction

    function automatic logic [31:0] tdiv(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // Work out one instruction; update the shadow state only when commit is set.
    function automatic answer_t exec_instr(logic [3:0] op, logic [31:0] opd, bit commit);
        answer_t r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] wval;
        int   widx;
        int   nd;
        logic nh;
        logic [2:0] st;
        r = '{1'b0, 32'd0, 1'b0, ST_OK};
        st = ST_OK;
        widx = -1;
        wval = '0;
        nd = shadow_depth;
        nh = shadow_halt;
        if (shadow_halt) begin
            st = ST_IGNORED;
        end else if (op > OP_HALT) begin
            st = ST_BADOP;
        end else begin
            case (op)
                OP_PUSH, OP_IN: begin
                    if (shadow_depth >= STACK_DEPTH) st = ST_OVER;
                    else begin
                        widx = shadow_depth;
                        wval = opd;
                        nd = shadow_depth + 1;
                    end
                end
                OP_POP, OP_OUT, OP_SQRT, OP_SIN, OP_COS: begin
                    if (shadow_depth < 1) st = ST_UNDER;
                    else begin
                        a = shadow_stk[shadow_depth-1];
                        widx = shadow_depth - 1;
                        case (op)
                            OP_POP: begin
                                nd = shadow_depth - 1;
                                widx = -1;
                            end
                            OP_OUT: begin
                                nd = shadow_depth - 1;
                                widx = -1;
                                r.ov = 1'b1;
                                r.val = a;
                            end
                            OP_SQRT: begin
                                if (a[31]) begin
                                    st = ST_NEGSQ;
                                    widx = -1;
                                end else wval = isqrt(a);
                            end
                            OP_SIN: wval = '0;
                            default: wval = (a == 0) ? 32'd1 : 32'd0;
                        endcase
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (shadow_depth < 2) st = ST_UNDER;
                    else begin
                        b = shadow_stk[shadow_depth-1];
                        a = shadow_stk[shadow_depth-2];
                        case (op)
                            OP_ADD: wval = a + b;
                            OP_SUB: wval = a - b;
                            OP_MUL: wval = a * b;
                            default: begin
                                if (b == 0) st = ST_DIVZ;
                                else wval = tdiv(a, b);
                            end
                        endcase
                        if (st == ST_OK) begin
                            nd = shadow_depth - 1;
                            widx = shadow_depth - 2;
                        end
                    end
                end
                OP_HALT: nh = 1'b1;
                default: ;
            endcase
        end
        if (st != ST_OK && st != ST_IGNORED) nh = 1'b1;
        r.hl = nh;
        r.st = st;
        if (commit) begin
            if (widx >= 0) shadow_stk[widx] = wval;
            shadow_depth = nd;
            shadow_halt = nh;
        end
        return r;
    endfunction

    task automatic issue(logic [3:0] op, logic [31:0] opd);
        expected_answers.push_back(exec_instr(op, opd, 1'b1));
        pending_instrs.push_back('{op, opd});
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return MIN_W;
            1: return MAX_W;
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pick a random op that cannot stop the machine.
    task automatic issue_safe_random();
        logic [3:0]  op;
        logic [31:0] opd;
        answer_t probe;
        int w;
        w = $urandom_range(0, 99);
        if (w < 18) op = OP_PUSH;
        else if (w < 28) op = OP_IN;
        else if (w < 34) op = OP_POP;
        else if (w < 44) op = OP_OUT;
        else if (w < 52) op = OP_ADD;
        else if (w < 60) op = OP_SUB;
        else if (w < 68) op = OP_MUL;
        else if (w < 80) op = OP_DIV;
        else if (w < 88) op = OP_SQRT;
        else if (w < 92) op = OP_SIN;
        else if (w < 96) op = OP_COS;
        else op = OP_DUMP;
        opd = rand_word();
        probe = exec_instr(op, opd, 1'b0);
        if (probe.st != ST_OK) op = OP_DUMP;
        issue(op, opd);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at beat %0d: %s got %h want %h", beats_out, what, got, want);
        errors++;
    endtask

    // Program: directed opening, random body with fill/drain runs, one terminator, then 12 random ops.
    initial begin
        int kind;
        for (int i = 0; i < STACK_DEPTH; i++) shadow_stk[i] = '0;
        issue(OP_PUSH, MAX_W);
        issue(OP_IN, 32'd1);
        issue(OP_ADD, $urandom);          // wraps to most negative
        issue(OP_PUSH, 32'hFFFF_FFFF);
        issue(OP_DIV, $urandom);          // most negative over minus one
        issue(OP_OUT, $urandom);
        issue(OP_PUSH, 32'd7);
        issue(OP_PUSH, 32'hFFFF_FFFE);
        issue(OP_DIV, '0);                // truncates toward zero
        issue(OP_PUSH, MIN_W);
        issue(OP_MUL, '0);
        issue(OP_PUSH, 32'd5);
        issue(OP_SUB, '0);
        issue(OP_PUSH, MAX_W);
        issue(OP_SQRT, '0);
        issue(OP_PUSH, '0);
        issue(OP_SQRT, '0);
        issue(OP_COS, '0);                // cosine of zero
        issue(OP_COS, '0);                // cosine of nonzero
        issue(OP_SIN, 32'hFFFF_FFFF);
        issue(OP_DUMP, MIN_W);
        issue(OP_POP, '0);
        issue(OP_OUT, '0);
        issue(OP_OUT, '0);
        for (int n = 0; n < 900; n++) begin
            if (n % 200 == 100) begin
                while (shadow_depth < STACK_DEPTH) issue(OP_PUSH, $urandom);
            end else if (n % 200 == 199) begin
                while (shadow_depth > 0) issue($urandom_range(0, 1) ? OP_OUT : OP_POP, $urandom);
            end
            issue_safe_random();
        end
        kind = $urandom_range(0, 5);
        case (kind)
            0: issue(OP_HALT, $urandom);
            1: issue(4'(13 + $urandom_range(0, 2)), $urandom);
            2: begin
                while (shadow_depth > 0) issue(OP_POP, '0);
                issue(OP_OUT, '0);
            end
            3: begin
                while (shadow_depth < STACK_DEPTH) issue(OP_IN, $urandom);
                issue(OP_PUSH, $urandom);
            end
            4: begin
                if (shadow_depth >= STACK_DEPTH - 1) issue(OP_POP, '0);
                if (shadow_depth == 0) issue(OP_PUSH, 32'd9);
                issue(OP_PUSH, '0);
                issue(OP_DIV, '0);
            end
            default: begin
                if (shadow_depth >= STACK_DEPTH) issue(OP_POP, '0);
                issue(OP_PUSH, 32'h8000_0001);
                issue(OP_SQRT, '0);
            end
        endcase
        for (int i = 0; i < 12; i++) issue(4'($urandom_range(0, 15)), $urandom);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_instrs.size() == 0 && !s_valid && expected_answers.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Driver: bursts of beats with random gaps between them.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        instr_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 25) : 0;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_instrs.size() > 0) begin
                it = pending_instrs.pop_front();
                burst_left--;
                s_valid <= 1'b1;
                s_op <= it.op;
                s_operand <= it.opd;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat; drive m_ready with its own stall pattern.
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    always @(posedge aclk) begin
        answer_t e;
        logic rdy;
        if (aresetn && m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                report("unexpected beat", m_out_value, 32'd0);
            end else begin
                e = expected_answers.pop_front();
                if (m_out_valid !== e.ov) report("out_valid", 32'(m_out_valid), 32'(e.ov));
                if (m_out_value !== e.val) report("out_value", m_out_value, e.val);
                if (m_halted !== e.hl) report("halted", 32'(m_halted), 32'(e.hl));
                if (m_status !== e.st) report("status", 32'(m_status), 32'(e.st));
            end
            beats_out++;
        end
        // Long hold-off once, so the block fills and stalls its input.
        if (!held_once && beats_out == 400) begin
            held_once = 1'b1;
            hold_left = 300;
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (ready_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            default: rdy = (mode_left % 7) > 2;
        endcase
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end
        m_ready <= aresetn ? rdy : 1'b0;
    end

    // Watchdog: give up after too many cycles with no beat on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

/* sim.f */
rtl/smx_pkg.sv
rtl/smx_cell.sv
rtl/smx_iter.sv
rtl/stack_machine_executor.sv
tb/testbench.sv
